@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C register-access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int DEV_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int RDATA_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b1;

    localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST = 8'd200;
    localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 8'd1;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    typedef enum logic [1:0] {
        K_NONE,
        K_TICK,
        K_WRITE,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DEV_W-1:0]   dev_addr;
        logic [BYTE_W-1:0]  reg_addr;
        logic [BYTE_W-1:0]  write_data;
        logic               sda_in;
    } t_item;

    typedef struct packed {
        logic [RDATA_W-1:0]  read_data;
        logic [STATUS_W-1:0] status;
        logic                done;
        logic                busy;
        logic                sda_low;
        logic                scl;
    } t_res;

endpackage

@@ rtl/i2cm_front.sv @@
// ----------------------------------------------------------------------------
// i2cm_front
// Decodes incoming beats into ticks and commands and holds them in a
// two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_func,
    input  logic [i2cm_pkg::DEV_W-1:0] i_dev_addr,
    input  logic [i2cm_pkg::BYTE_W-1:0] i_reg_addr,
    input  logic [i2cm_pkg::BYTE_W-1:0] i_write_data,
    input  logic                       i_sda_in,
    output logic                       o_q_valid,
    output i2cm_pkg::t_item            o_q_item,
    input  logic                       i_q_pop
);
    import i2cm_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    t_item              n_item;
    logic               push;

    always_comb begin
        n_item.dev_addr   = i_dev_addr;
        n_item.reg_addr   = i_reg_addr;
        n_item.write_data = i_write_data;
        n_item.sda_in     = i_sda_in;
        case (i_func)
            FUNC_TICK:  n_item.kind = K_TICK;
            FUNC_WRITE: n_item.kind = K_WRITE;
            FUNC_READ:  n_item.kind = K_READ;
            default:    n_item.kind = K_NONE;
        endcase
    end

    assign o_ready   = (r_count != (PTR_W+1)'(DEPTH)) ? 1'b1 : 1'b0;
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({push, i_q_pop})
                2'b10:   r_count <= r_count + (PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/i2cm_seq.sv @@
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: advances the START / byte / ACK / read / STOP phases one
// queued beat per cycle unless stalled, and registers bus levels and status.
// ----------------------------------------------------------------------------
module i2cm_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [i2cm_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_q_valid,
    input  i2cm_pkg::t_item               i_q_item,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output i2cm_pkg::t_res                o_res
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_S0, PH_S1, PH_S2, PH_B0, PH_B1, PH_B2,
        PH_A0, PH_A1, PH_A2, PH_R0, PH_R1, PH_K0, PH_K1,
        PH_P0, PH_P1, PH_P2
    } t_phase;

    logic [CFG_W-1:0]    r_ack_timeout;
    logic [CFG_W-1:0]    r_half;

    t_phase              r_phase,      n_phase;
    logic [3:0]          r_bit_count,  n_bit_count;
    logic [BYTE_W-1:0]   r_shift,      n_shift;
    logic [RDATA_W-1:0]  r_read_word,  n_read_word;
    logic [CFG_W-1:0]    r_delay,      n_delay;
    logic [CFG_W-1:0]    r_ack_wait,   n_ack_wait;
    logic                r_is_read,    n_is_read;
    logic [DEV_W-1:0]    r_dev,        n_dev;
    logic [BYTE_W-1:0]   r_reg,        n_reg;
    logic [BYTE_W-1:0]   r_data,       n_data;
    logic [STATUS_W-1:0] r_status,     n_status;
    logic [2:0]          r_stage,      n_stage;
    logic                r_out_valid;
    t_res                r_out,        n_out;
    logic                done;
    logic [2:0]          stage_inc;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign stage_inc = r_stage + 3'd1;

    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_read_word = r_read_word;
        n_delay     = r_delay;
        n_ack_wait  = r_ack_wait;
        n_is_read   = r_is_read;
        n_dev       = r_dev;
        n_reg       = r_reg;
        n_data      = r_data;
        n_status    = r_status;
        n_stage     = r_stage;
        done        = 1'b0;

        if (o_q_pop) begin
            case (i_q_item.kind)
                K_TICK: begin
                    if (r_phase == PH_A2) begin
                        if (!i_q_item.sda_in) begin
                            // ACK seen: move on to the next byte, a repeated START or the STOP
                            n_stage = stage_inc;
                            n_delay = '0;
                            if (stage_inc == 3'd1) begin
                                n_shift = r_reg; n_bit_count = '0; n_phase = PH_B0;
                            end else if (!r_is_read) begin
                                if (stage_inc == 3'd2) begin
                                    n_shift = r_data; n_bit_count = '0; n_phase = PH_B0;
                                end else begin
                                    n_phase = PH_P0;
                                end
                            end else if (stage_inc == 3'd2) begin
                                n_phase = PH_S0;
                            end else begin
                                n_bit_count = '0;
                                n_phase     = PH_R0;
                            end
                        end else if (r_ack_wait >= r_ack_timeout) begin
                            n_status = r_is_read ? STATUS_W'(1) : stage_inc[STATUS_W-1:0];
                            n_phase  = PH_P0;
                            n_delay  = '0;
                        end else begin
                            n_ack_wait = r_ack_wait + CFG_W'(1);
                        end
                    end else if (r_phase != PH_IDLE) begin
                        if (r_phase == PH_R1 && r_delay == '0) begin
                            n_read_word = {r_read_word[RDATA_W-2:0], i_q_item.sda_in};
                        end
                        if ({1'b0, r_delay} + 9'd1 >= {1'b0, r_half}) begin
                            n_delay = '0;
                            done    = (r_phase == PH_P2);
                            case (r_phase)
                                PH_S0: n_phase = PH_S1;
                                PH_S1: n_phase = PH_S2;
                                PH_S2: begin
                                    n_shift     = {r_dev, (r_stage == 3'd2)};
                                    n_bit_count = '0;
                                    n_phase     = PH_B0;
                                end
                                PH_B0: n_phase = PH_B1;
                                PH_B1: n_phase = PH_B2;
                                PH_B2: begin
                                    n_shift     = {r_shift[BYTE_W-2:0], 1'b0};
                                    n_bit_count = r_bit_count + 4'd1;
                                    n_phase     = (r_bit_count + 4'd1 >= 4'd8) ? PH_A0 : PH_B0;
                                end
                                PH_A0: n_phase = PH_A1;
                                PH_A1: begin
                                    n_ack_wait = '0;
                                    n_phase    = PH_A2;
                                end
                                PH_R0: n_phase = PH_R1;
                                PH_R1: begin
                                    n_bit_count = r_bit_count + 4'd1;
                                    n_phase     = (r_bit_count + 4'd1 >= 4'd8) ? PH_K0 : PH_R0;
                                end
                                PH_K0: n_phase = PH_K1;
                                PH_K1: begin
                                    if (r_stage == 3'd3) begin
                                        n_stage     = 3'd4;
                                        n_bit_count = '0;
                                        n_phase     = PH_R0;
                                    end else begin
                                        n_phase = PH_P0;
                                    end
                                end
                                PH_P0: n_phase = PH_P1;
                                PH_P1: n_phase = PH_P2;
                                default: n_phase = PH_IDLE;
                            endcase
                        end else begin
                            n_delay = r_delay + CFG_W'(1);
                        end
                    end
                end
                K_WRITE, K_READ: begin
                    if (r_phase == PH_IDLE) begin
                        n_is_read   = (i_q_item.kind == K_READ);
                        n_dev       = i_q_item.dev_addr;
                        n_reg       = i_q_item.reg_addr;
                        n_data      = i_q_item.write_data;
                        n_status    = '0;
                        n_read_word = '0;
                        n_stage     = '0;
                        n_bit_count = '0;
                        n_ack_wait  = '0;
                        n_delay     = '0;
                        n_phase     = PH_S0;
                    end
                end
                default: ;
            endcase
        end

        n_out.scl       = 1'b1;
        n_out.sda_low   = 1'b0;
        case (n_phase)
            PH_S1: n_out.sda_low = 1'b1;
            PH_S2: begin n_out.scl = 1'b0; n_out.sda_low = 1'b1; end
            PH_B0, PH_B1: begin
                n_out.scl     = 1'b0;
                n_out.sda_low = !n_shift[BYTE_W-1];
            end
            PH_B2: n_out.sda_low = !n_shift[BYTE_W-1];
            PH_A0, PH_R0: n_out.scl = 1'b0;
            PH_K0: begin n_out.scl = 1'b0; n_out.sda_low = (n_stage == 3'd3); end
            PH_K1: n_out.sda_low = (n_stage == 3'd3);
            PH_P0: begin n_out.scl = 1'b0; n_out.sda_low = 1'b1; end
            PH_P1: n_out.sda_low = 1'b1;
            default: ;
        endcase
        n_out.busy      = (n_phase != PH_IDLE);
        n_out.done      = done;
        n_out.status    = n_status;
        n_out.read_data = n_read_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RST;
            r_half        <= HALF_PERIOD_RST;
            r_phase       <= PH_IDLE;
            r_bit_count   <= '0;
            r_shift       <= '0;
            r_read_word   <= '0;
            r_delay       <= '0;
            r_ack_wait    <= '0;
            r_is_read     <= 1'b0;
            r_dev         <= '0;
            r_reg         <= '0;
            r_data        <= '0;
            r_status      <= '0;
            r_stage       <= '0;
            r_out_valid   <= 1'b0;
            r_out         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_wdata;
                    CFG_HALF_PERIOD: r_half        <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_read_word <= n_read_word;
            r_delay     <= n_delay;
            r_ack_wait  <= n_ack_wait;
            r_is_read   <= n_is_read;
            r_dev       <= n_dev;
            r_reg       <= n_reg;
            r_data      <= n_data;
            r_status    <= n_status;
            r_stage     <= n_stage;
            if (o_q_pop) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done |-> !r_out.busy)
        else $error("done flagged while still busy");

    a_idle_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_delay == '0)
        else $error("delay count left running in idle");

    a_cmd_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop && r_phase == PH_IDLE &&
        (i_q_item.kind == K_WRITE || i_q_item.kind == K_READ) |=> r_phase == PH_S0)
        else $error("command in idle did not start the bus");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= 4'd8)
        else $error("bit count out of range");

    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_is_read && r_status != '0 |-> r_status == STATUS_W'(1))
        else $error("read reported a byte-specific NACK");

endmodule

@@ rtl/i2c_master_register_access.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_access
// Bit-banged I2C master for one-byte register writes and two-byte reads.
// ----------------------------------------------------------------------------
// Every input beat (a tick carrying the sampled SDA level, or a command)
// yields exactly one output beat with the SCL level, the SDA pull-down, busy,
// a done pulse, the last status and the read word. The block takes one beat
// per cycle while the output is not stalled: the front end decodes beats
// into a two-entry queue and the sequencer retires one queued beat per cycle
// into a registered output, so a beat passes through the queue and then the
// output register. Bus timing is counted in ticks, half_period_ticks per
// interval; the user must write configuration through i_cfg_* only while no
// beat is in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module i2c_master_register_access (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [i2cm_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // dev_addr[6:0], reg_addr[14:7], write_data[22:15], sda_in[23]
    input  logic [23:0]                    s_axis_tdata,
    // func[1:0]
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // scl[0], sda_low[1], busy_res[2], done_res[3], status[5:4],
    // read_data[21:6], zero[23:22]
    output logic [23:0]                    m_axis_tdata
);
    import i2cm_pkg::*;

    logic  q_valid;
    logic  q_pop;
    t_item q_item;
    t_res  res;

    i2cm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_func       (s_axis_tuser),
        .i_dev_addr   (s_axis_tdata[6:0]),
        .i_reg_addr   (s_axis_tdata[14:7]),
        .i_write_data (s_axis_tdata[22:15]),
        .i_sda_in     (s_axis_tdata[23]),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    i2cm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {2'b00, res.read_data, res.status, res.done, res.busy,
                           res.sda_low, res.scl};

endmodule
